// ===== hdl/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants for the ntc converter
// common formats and status codes used by the pipeline stages
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int RES_W  = 24;
    localparam int COEF_W = 48;
    localparam int TEMP_W = 16;
    localparam int STAT_W = 2;

    localparam logic [27:0] LN2_Q28      = 28'd186065280;
    localparam logic [16:0] KELVIN_CENTI = 17'd27315;
    localparam logic [16:0] TEMP_MAX     = 17'd32767;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_NPOS = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    // item travelling through the log pipeline
    typedef struct packed {
        logic        valid;
        logic        zero;
        logic [4:0]  k;
        logic [32:0] x;
        logic [29:0] frac;
    } log_stage_t;

    // item travelling through horner and divide stages
    typedef struct packed {
        logic        valid;
        logic        zero;
        logic [63:0] acc;
    } poly_stage_t;

endpackage

// ===== hdl/ntc_log.sv =====
// ----------------------------------------------------------------------------
// ntc_log: pipelined natural log
// normalizes r, squares the mantissa once per stage, scales by ln2
// ----------------------------------------------------------------------------
module ntc_log
    import ntc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [RES_W-1:0] in_r,
    output logic             out_valid,
    output logic             out_zero,
    output logic [34:0]      out_l
);

    log_stage_t st_reg [0:30];
    logic [4:0] k_c;
    logic [34:0] lg_c;
    logic [62:0] lprod_c;
    logic [34:0] l_reg;
    logic        lv_reg, lz_reg;

    always_comb begin
        k_c = '0;
        for (int i = 1; i < RES_W; i++)
            if (in_r[i]) k_c = 5'(i);
    end

    // one fraction bit per stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= 30; s++) st_reg[s].valid <= 1'b0;
            lv_reg <= 1'b0;
        end else if (en) begin
            st_reg[0].valid <= in_valid;
            st_reg[0].zero  <= (in_r == '0);
            st_reg[0].k     <= k_c;
            st_reg[0].x     <= 33'({9'd0, in_r} << (5'd31 - k_c));
            st_reg[0].frac  <= '0;
            for (int s = 1; s <= 30; s++) begin
                logic [65:0] sq;
                logic [34:0] xs;
                logic [29:0] fr;
                sq = st_reg[s-1].x * st_reg[s-1].x;
                xs = sq[65:31];
                fr = st_reg[s-1].frac;
                st_reg[s].valid <= st_reg[s-1].valid;
                st_reg[s].zero  <= st_reg[s-1].zero;
                st_reg[s].k     <= st_reg[s-1].k;
                if (xs[34:32] != 3'd0) begin
                    st_reg[s].x <= 33'(xs >> 1);
                    fr[30-s] = 1'b1;
                end else begin
                    st_reg[s].x <= xs[32:0];
                end
                st_reg[s].frac <= fr;
            end
            lv_reg <= st_reg[30].valid;
            lz_reg <= st_reg[30].zero;
            l_reg  <= 35'((lprod_c + 63'(1 << 27)) >> 28);
        end
    end

    assign lg_c    = {st_reg[30].k, st_reg[30].frac};
    assign lprod_c = 63'(lg_c) * 63'(LN2_Q28);

    assign out_valid = lv_reg;
    assign out_zero  = lz_reg;
    assign out_l     = l_reg;

endmodule

// ===== hdl/ntc_horner.sv =====
// ----------------------------------------------------------------------------
// ntc_horner: one horner step per four stages
// magnitude, split multiply by l, round, then sign and add next coefficient
// ----------------------------------------------------------------------------
module ntc_horner
    import ntc_pkg::*;
#(
    parameter int POLY_DEGREE = 3
)(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic              in_zero,
    input  logic [34:0]       in_l,
    input  logic [COEF_W-1:0] coef [0:3],
    output poly_stage_t       out_st
);

    poly_stage_t st_reg [0:POLY_DEGREE];
    logic [34:0] l_reg [0:POLY_DEGREE-1];
    // magnitude stage
    logic        av_reg [1:POLY_DEGREE];
    logic        az_reg [1:POLY_DEGREE];
    logic        an_reg [1:POLY_DEGREE];
    logic [63:0] am_reg [1:POLY_DEGREE];
    logic [34:0] al_reg [1:POLY_DEGREE];
    // partial products, low and high 32 bits of the magnitude times l
    logic        bv_reg [1:POLY_DEGREE];
    logic        bz_reg [1:POLY_DEGREE];
    logic        bn_reg [1:POLY_DEGREE];
    logic [66:0] blo_reg [1:POLY_DEGREE];
    logic [66:0] bhi_reg [1:POLY_DEGREE];
    logic [34:0] bl_reg [1:POLY_DEGREE];
    // rounded product stage between adds
    logic        pv_reg [1:POLY_DEGREE];
    logic        pz_reg [1:POLY_DEGREE];
    logic        pn_reg [1:POLY_DEGREE];
    logic [63:0] pm_reg [1:POLY_DEGREE];
    logic [34:0] pl_reg [1:POLY_DEGREE];

    function automatic logic [63:0] coef_of(input int i, input logic [COEF_W-1:0] c [0:3]);
        if (i > 3) return '0;
        return 64'(signed'(c[i]));
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= POLY_DEGREE; s++) st_reg[s].valid <= 1'b0;
            for (int s = 1; s <= POLY_DEGREE; s++) begin
                av_reg[s] <= 1'b0;
                bv_reg[s] <= 1'b0;
                pv_reg[s] <= 1'b0;
            end
        end else if (en) begin
            st_reg[0].valid <= in_valid;
            st_reg[0].zero  <= in_zero;
            st_reg[0].acc   <= coef_of(POLY_DEGREE, coef);
            l_reg[0]        <= in_l;
            for (int s = 1; s <= POLY_DEGREE; s++) begin
                logic [98:0] sm;
                sm = {bhi_reg[s], 32'd0} + 99'(blo_reg[s]) + 99'(1 << 29);
                av_reg[s] <= st_reg[s-1].valid;
                az_reg[s] <= st_reg[s-1].zero;
                an_reg[s] <= st_reg[s-1].acc[63];
                am_reg[s] <= st_reg[s-1].acc[63] ? (64'd0 - st_reg[s-1].acc)
                                                 : st_reg[s-1].acc;
                al_reg[s] <= l_reg[s-1];
                bv_reg[s]  <= av_reg[s];
                bz_reg[s]  <= az_reg[s];
                bn_reg[s]  <= an_reg[s];
                bl_reg[s]  <= al_reg[s];
                blo_reg[s] <= {35'd0, am_reg[s][31:0]} * {32'd0, al_reg[s]};
                bhi_reg[s] <= {35'd0, am_reg[s][63:32]} * {32'd0, al_reg[s]};
                pv_reg[s] <= bv_reg[s];
                pz_reg[s] <= bz_reg[s];
                pn_reg[s] <= bn_reg[s];
                pl_reg[s] <= bl_reg[s];
                pm_reg[s] <= sm[93:30];
                st_reg[s].valid <= pv_reg[s];
                st_reg[s].zero  <= pz_reg[s];
                st_reg[s].acc   <= (pn_reg[s] ? (64'd0 - pm_reg[s]) : pm_reg[s])
                                   + coef_of(POLY_DEGREE - s, coef);
                if (s < POLY_DEGREE) l_reg[s] <= pl_reg[s];
            end
        end
    end

    assign out_st = st_reg[POLY_DEGREE];

endmodule

// ===== hdl/ntc_recip.sv =====
// ----------------------------------------------------------------------------
// ntc_recip: pipelined restoring divide of 100*2^56 + s/2 by s
// one quotient bit per stage, then offset and saturate
// ----------------------------------------------------------------------------
module ntc_recip
    import ntc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  poly_stage_t       in_st,
    output logic              out_valid,
    output logic [TEMP_W-1:0] out_temp,
    output logic [STAT_W-1:0] out_status
);

    localparam int QB = 64;

    logic        v_reg [0:QB];
    logic        z_reg [0:QB];
    logic        n_reg [0:QB];
    logic [63:0] d_reg [0:QB];
    logic [63:0] n_num [0:QB];
    logic [64:0] r_reg [0:QB];
    logic [63:0] q_reg [0:QB];
    logic        ov_reg;
    logic [TEMP_W-1:0] t_reg;
    logic [STAT_W-1:0] s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= QB; s++) v_reg[s] <= 1'b0;
            ov_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_st.valid;
            for (int s = 1; s <= QB; s++) v_reg[s] <= v_reg[s-1];
            ov_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg[0] <= in_st.zero;
            n_reg[0] <= in_st.acc[63] || (in_st.acc == '0);
            d_reg[0] <= in_st.acc;
            n_num[0] <= (64'd100 << 56) + (in_st.acc >> 1);
            r_reg[0] <= '0;
            q_reg[0] <= '0;
            for (int s = 1; s <= QB; s++) begin
                logic [64:0] tr;
                logic [63:0] qn;
                tr = {r_reg[s-1][63:0], n_num[s-1][QB-s]};
                qn = q_reg[s-1];
                z_reg[s] <= z_reg[s-1];
                n_reg[s] <= n_reg[s-1];
                d_reg[s] <= d_reg[s-1];
                n_num[s] <= n_num[s-1];
                if (tr >= {1'b0, d_reg[s-1]}) begin
                    r_reg[s] <= tr - {1'b0, d_reg[s-1]};
                    qn[QB-s] = 1'b1;
                end else begin
                    r_reg[s] <= tr;
                end
                q_reg[s] <= qn;
            end
            if (z_reg[QB]) begin
                t_reg <= '0; s_reg <= ST_ZERO;
            end else if (n_reg[QB]) begin
                t_reg <= '0; s_reg <= ST_NPOS;
            end else if (q_reg[QB] > 64'(TEMP_MAX) + 64'(KELVIN_CENTI)) begin
                t_reg <= TEMP_W'(TEMP_MAX); s_reg <= ST_SAT;
            end else begin
                t_reg <= TEMP_W'(q_reg[QB] - 64'(KELVIN_CENTI)); s_reg <= ST_OK;
            end
        end
    end

    assign out_valid  = ov_reg;
    assign out_temp   = t_reg;
    assign out_status = s_reg;

endmodule

// ===== hdl/ntc_resistance_to_temperature.sv =====
// ----------------------------------------------------------------------------
// ntc_resistance_to_temperature: steinhart-hart thermistor converter
// resistance in ohms to hundredths of a degree celsius with status
// ----------------------------------------------------------------------------
// channel | dir | tdata                 | tuser
// s_      | in  | resistance_ohms[23:0] | -
// m_      | out | temp_centi_c[15:0]    | status[1:0]
// cfg     | in  | apb, coef a..d at 0,8,16,24 (64-bit data)
//
// one item per cycle while the output is not stalled; the stages are log, horner
// and divide, in that order
// the whole pipeline advances together, it stalls when the output register
// is full and not taken, so nothing is lost or repeated
// reset clears valid bits and loads the default coefficients
// ----------------------------------------------------------------------------
module ntc_resistance_to_temperature
    import ntc_pkg::*;
#(
    parameter int POLY_DEGREE = 3
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // resistance_ohms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // temp_centi_c
    output logic [7:0]  m_tuser,   // status [1:0], zeros above
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [COEF_W-1:0] coef_reg [0:3];
    logic en;
    logic lv, lz;
    logic [34:0] l;
    poly_stage_t pst;
    logic pv;
    logic [TEMP_W-1:0] pt;
    logic [STAT_W-1:0] ps;

    // pipeline moves when output is free or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign pready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= 48'd81364000000000;
            coef_reg[1] <= 48'd16870000000000;
            coef_reg[2] <= 48'd0;
            coef_reg[3] <= 48'd6318000000;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            coef_reg[paddr[4:3]] <= pwdata[COEF_W-1:0];
        end
    end

    assign prdata = (paddr[2:0] == 3'd0) ? {16'd0, coef_reg[paddr[4:3]]} : 64'd0;

    ntc_log u_log (
        .aclk, .aresetn, .en,
        .in_valid (s_tvalid), .in_r (s_tdata),
        .out_valid (lv), .out_zero (lz), .out_l (l)
    );

    ntc_horner #(.POLY_DEGREE(POLY_DEGREE)) u_horner (
        .aclk, .aresetn, .en,
        .in_valid (lv), .in_zero (lz), .in_l (l),
        .coef (coef_reg), .out_st (pst)
    );

    ntc_recip u_recip (
        .aclk, .aresetn, .en,
        .in_st (pst),
        .out_valid (pv), .out_temp (pt), .out_status (ps)
    );

    assign m_tvalid = pv;
    assign m_tdata  = pt;
    assign m_tuser  = {6'd0, ps};

    // saturated items always carry the max temperature
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == ST_SAT |-> m_tdata == 16'h7fff) else $error("sat");
    // error items carry zero temperature
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == ST_ZERO || m_tuser[1:0] == ST_NPOS) |-> m_tdata == 16'd0)
        else $error("err");
    // stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");

endmodule

// ===== tb/tb_ntc_resistance_to_temperature.sv =====
// ----------------------------------------------------------------------------
// tb_ntc_resistance_to_temperature: self-checking bench for the ntc converter
// streams resistances through the steinhart-hart pipeline under random
// idling and backpressure, predicts every temperature and status in fixed
// point, and compares in order; coefficients are rewritten between phases
// ----------------------------------------------------------------------------
module tb_ntc_resistance_to_temperature
    import ntc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic signed [15:0] temp;
        status_t            st;
    } conversion_t;

    // directed row: resistance, plus a typed expectation where obvious
    typedef struct {
        logic [23:0]        ohms;
        bit                 typed;
        logic signed [15:0] temp;
        status_t            st;
    } ohms_row_t;

    typedef enum int {
        REG_COEF_A = 0,
        REG_COEF_B = 1,
        REG_COEF_C = 2,
        REG_COEF_D = 3
    } coef_reg_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // resistance_ohms
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // temp_centi_c
    logic [7:0]  m_tuser;   // status [1:0], zeros above
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    ntc_resistance_to_temperature dut (.*);

    // bench copy of the coefficient registers, 48-bit signed
    logic [47:0] coefs [4];

    conversion_t pending_temps [$];
    int          error_count;
    int          cycle_count;
    int          items_sent;
    int          items_checked;
    int          status_seen [4];
    bit          burst_mode;      // sender offers back to back
    bit          hold_done;

    // next directed item may carry a typed expectation
    bit                 row_typed;
    logic signed [15:0] row_temp;
    status_t            row_st;

    initial begin
        aclk = 1'b0;
    end

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // accumulator (q56) times log (q30), magnitude rounded half away from zero
    function automatic logic [63:0] scale_by_log(input logic [63:0] acc,
                                                 input logic [63:0] lg);
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [63:0]  res;
        neg  = acc[63];
        mag  = neg ? (64'd0 - acc) : acc;
        prod = {64'd0, mag} * {64'd0, lg};
        prod = prod + (128'd1 << 29);
        res  = prod[93:30];
        return neg ? (64'd0 - res) : res;
    endfunction

    function automatic conversion_t convert_ohms(input logic [23:0] ohms);
        conversion_t res;
        int          k;
        logic [63:0] mant;
        logic [63:0] log2_q30;
        logic [63:0] ln_q30;
        logic [63:0] acc;
        logic [63:0] num;
        logic [63:0] q;
        k = 0;
        if (ohms == 24'd0) begin
            res.temp = '0;
            res.st   = ST_ZERO;
            return res;
        end
        for (int i = 0; i < 24; i++)
            if (ohms[i]) k = i;
        // mantissa in [1,2) with 31 fraction bits, one log bit per squaring
        mant     = 64'(ohms) << (31 - k);
        log2_q30 = 64'(k) << 30;
        for (int i = 29; i >= 0; i--) begin
            mant = (mant * mant) >> 31;
            if (mant >= 64'h1_0000_0000) begin
                mant        = mant >> 1;
                log2_q30[i] = 1'b1;
            end
        end
        ln_q30 = (log2_q30 * 64'(LN2_Q28) + (64'd1 << 27)) >> 28;
        // horner, highest coefficient first
        acc = '0;
        for (int d = 3; d >= 0; d--)
            acc = scale_by_log(acc, ln_q30) + {{16{coefs[d][47]}}, coefs[d]};
        if (acc[63] || acc == 64'd0) begin
            res.temp = '0;
            res.st   = ST_NPOS;
            return res;
        end
        num = (64'd100 << 56) + (acc >> 1);
        q   = num / acc;
        if (q > 64'(TEMP_MAX) + 64'(KELVIN_CENTI)) begin
            res.temp = 16'sd32767;
            res.st   = ST_SAT;
        end else begin
            res.temp = 16'(q - 64'(KELVIN_CENTI));
            res.st   = ST_OK;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("[%0t] mismatch on item %0d: %s got %0d want %0d",
                 $realtime, items_checked, what, got, want);
        error_count++;
    endtask

    // accepted input: queue its expected temperature
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            conversion_t exp_c;
            exp_c = convert_ohms(s_tdata);
            if (row_typed && (exp_c.temp !== row_temp || exp_c.st !== row_st))
                report_mismatch("bench prediction vs table", exp_c.temp, row_temp);
            pending_temps.push_back(exp_c);
        end
    end

    // accepted result: compare against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            conversion_t want;
            if (pending_temps.size() == 0) begin
                report_mismatch("unexpected result, temp", $signed(m_tdata), 0);
            end else begin
                want = pending_temps.pop_front();
                if (m_tuser[1:0] !== want.st)
                    report_mismatch("status", m_tuser[1:0], want.st);
                if ($signed(m_tdata) !== want.temp)
                    report_mismatch("temp_centi_c", $signed(m_tdata), want.temp);
                if (m_tuser[7:2] !== 6'd0)
                    report_mismatch("tuser pad", m_tuser[7:2], 0);
                status_seen[want.st]++;
            end
            items_checked++;
        end
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_temps.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------- receiver

    // random stall before each result; one long hold-off to fill the pipe
    initial begin
        int gap;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && items_sent > 60) begin
                // long stall while the sender keeps offering
                hold_done = 1'b1;
                m_tready  = 1'b0;
                repeat (400) @(negedge aclk);
            end
            gap = burst_mode ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
                @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ---------------------------------------------------------------- sender

    task automatic send_ohms(input logic [23:0] ohms);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 13);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = ohms;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // spread over all magnitudes so small and large resistances both show up
    function automatic logic [23:0] random_ohms();
        int          width;
        logic [23:0] v;
        width = $urandom_range(1, 24);
        v     = 24'($urandom) & ((24'd1 << width) - 24'd1);
        v[width - 1] = 1'b1;
        if ($urandom_range(0, 49) == 0) v = 24'd0;
        return v;
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            send_ohms(random_ohms());
        end
        burst_mode = 1'b0;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // ---------------------------------------------------------------- config

    task automatic write_coef(input coef_reg_t idx, input logic [47:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 5'(8 * idx);
        pwdata  = {{16{value[47]}}, value};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        coefs[idx] = value;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_all(input logic [47:0] a, input logic [47:0] b,
                             input logic [47:0] c, input logic [47:0] d);
        write_coef(REG_COEF_A, a);
        write_coef(REG_COEF_B, b);
        write_coef(REG_COEF_C, c);
        write_coef(REG_COEF_D, d);
    endtask

    task automatic wait_idle();
        while (pending_temps.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- directed

    ohms_row_t ohms_table [] = '{
        '{24'd0,        1'b1, 16'sd0,     ST_ZERO},  // zero resistance
        '{24'd1,        1'b1, 16'sd32767, ST_SAT},   // ln = 0, far too hot
        '{24'd2,        1'b0, 16'sd0,     ST_OK},
        '{24'd3,        1'b0, 16'sd0,     ST_OK},
        '{24'd100,      1'b0, 16'sd0,     ST_OK},
        '{24'd1000,     1'b0, 16'sd0,     ST_OK},
        '{24'd4700,     1'b0, 16'sd0,     ST_OK},
        '{24'd10000,    1'b0, 16'sd0,     ST_OK},
        '{24'd33000,    1'b0, 16'sd0,     ST_OK},
        '{24'd100000,   1'b0, 16'sd0,     ST_OK},
        '{24'd1000000,  1'b0, 16'sd0,     ST_OK},
        '{24'h555555,   1'b0, 16'sd0,     ST_OK},
        '{24'hAAAAAA,   1'b0, 16'sd0,     ST_OK},
        '{24'h7FFFFF,   1'b0, 16'sd0,     ST_OK},
        '{24'h800000,   1'b0, 16'sd0,     ST_OK},
        '{24'hFFFFFF,   1'b0, 16'sd0,     ST_OK},    // largest resistance
        '{24'd0,        1'b1, 16'sd0,     ST_ZERO}
    };

    localparam logic [47:0] COEF_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] COEF_MIN = 48'h8000_0000_0000;

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_mode = 1'b0;
        row_typed  = 1'b0;
        row_temp   = '0;
        row_st     = ST_OK;
        error_count   = 0;
        items_sent    = 0;
        items_checked = 0;
        cycle_count   = 0;
        status_seen   = '{0, 0, 0, 0};
        // reset values of the coefficient registers
        coefs[REG_COEF_A] = 48'd81364000000000;
        coefs[REG_COEF_B] = 48'd16870000000000;
        coefs[REG_COEF_C] = 48'd0;
        coefs[REG_COEF_D] = 48'd6318000000;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed rows with reset coefficients
        foreach (ohms_table[i]) begin
            @(negedge aclk);
            // drop the previous item before its expectation is replaced
            s_tvalid  = 1'b0;
            row_typed = ohms_table[i].typed;
            row_temp  = ohms_table[i].temp;
            row_st    = ohms_table[i].st;
            send_ohms(ohms_table[i].ohms);
        end
        @(negedge aclk);
        s_tvalid  = 1'b0;
        row_typed = 1'b0;

        // bulk of the run on the default curve, includes the long stall
        send_random(260);
        wait_idle();

        // extreme coefficients: all largest, then all most negative
        write_all(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_random(20);
        wait_idle();
        write_all(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_random(20);
        wait_idle();

        // mixed signs, and fully random coefficient sets
        write_all(COEF_MIN, COEF_MAX, 48'd0, COEF_MIN);
        send_random(15);
        wait_idle();
        for (int s = 0; s < 3; s++) begin
            write_all(48'($urandom) | (48'($urandom) << 32),
                      48'($urandom) | (48'($urandom) << 32),
                      48'($urandom) | (48'($urandom) << 32),
                      48'($urandom) | (48'($urandom) << 32));
            send_random(15);
            wait_idle();
        end

        // realistic curve with a small square term
        write_all(48'd81364000000000, 48'd16870000000000, 48'd120000000,
                  48'd6318000000);
        send_random(40);
        wait_idle();

        $display("covered %0d items over 8 coefficient sets, long output stall",
                 items_checked);
        $display("status counts ok %0d zero %0d non-positive %0d saturated %0d",
                 status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_NPOS],
                 status_seen[ST_SAT]);
        if (error_count == 0 && pending_temps.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ntc_pkg.sv
hdl/ntc_log.sv
hdl/ntc_horner.sv
hdl/ntc_recip.sv
hdl/ntc_resistance_to_temperature.sv
tb/tb_ntc_resistance_to_temperature.sv
